>>> rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types and constants of the permutation inverter and checker.
// ----------------------------------------------------------------------------
package pic_pkg;

  // Width of one incoming permutation entry.
  localparam int unsigned ENTRY_W = 32;

  // Width of the slot and inverse value fields of a result.
  localparam int unsigned SLOT_W = 6;

  // Depths of the queue between front and back and of the result queue.
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // One classified entry, handed from the front to the back.
  typedef struct packed {
    logic [SLOT_W-1:0] idx;       // low bits of the entry value
    logic              over;      // position is past the maximum length
    logic              oor;       // value negative or not below the maximum length
    logic              ident_ok;  // value equals its position
    logic              last;      // final entry of the permutation
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [SLOT_W-1:0] inverse_value;
    logic [SLOT_W-1:0] slot;
    logic              end_of_run;
    logic              is_valid;
    logic              is_identity;
  } res_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_CHECK = 3'b010,
    ST_DRAIN = 3'b100
  } back_state_t;

endpackage

>>> rtl/pic_fifo.sv
// ----------------------------------------------------------------------------
// pic_fifo
// Small register queue with push/full and pop/empty sides and a fill count.
// ----------------------------------------------------------------------------
module pic_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [W-1:0]                 wr_data,
  output logic                         full,
  input  logic                         rd_en,
  output logic [W-1:0]                 rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/pic_front.sv
// ----------------------------------------------------------------------------
// pic_front
// Accepts entries, tracks their position and classifies each one.
// ----------------------------------------------------------------------------
module pic_front #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic                              q_full,
  input  logic signed [pic_pkg::ENTRY_W-1:0] in_entry_value,
  input  logic                              in_last_entry,
  output logic                              q_wr,
  output pic_pkg::cmd_t                     q_cmd
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0]            pos_r, pos_nxt;
  logic [pic_pkg::ENTRY_W-1:0] raw;
  logic                        neg;
  logic                        over;

  assign raw  = $unsigned(in_entry_value);
  assign neg  = raw[pic_pkg::ENTRY_W-1];
  assign over = (pos_r >= CNT_W'(MAX_LEN));
  assign q_wr = in_push && !q_full;

  always_comb begin
    q_cmd.idx      = raw[pic_pkg::SLOT_W-1:0];
    q_cmd.over     = over;
    q_cmd.oor      = neg || (raw >= pic_pkg::ENTRY_W'(MAX_LEN));
    q_cmd.ident_ok = !neg && (raw == pic_pkg::ENTRY_W'(pos_r));
    q_cmd.last     = in_last_entry;
  end

  // The position saturates at the maximum length and restarts after the last entry.
  always_comb begin
    pos_nxt = pos_r;
    if (q_wr) begin
      if (in_last_entry) begin
        pos_nxt = '0;
      end else if (!over) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> rtl/pic_back.sv
// ----------------------------------------------------------------------------
// pic_back
// Applies classified entries to the seen map and inverse table, then checks
// the run and drains the inverse into the result queue one slot per cycle while it has room.
// ----------------------------------------------------------------------------
module pic_back #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  pic_pkg::cmd_t                 q_cmd,
  output logic                          q_rd,
  input  logic [pic_pkg::OUT_CNT_W-1:0] out_cnt,
  input  logic                          out_pop_fire,
  output logic                          out_wr,
  output pic_pkg::res_t                 out_res
);

  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned OCC_W = pic_pkg::OUT_CNT_W + 1;

  pic_pkg::back_state_t state_r, state_nxt;

  logic [MAX_LEN-1:0] seen_r, seen_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               bad_r, bad_nxt;
  logic               ident_r, ident_nxt;
  logic [CNT_W-1:0]   slot_r, slot_nxt;
  logic               valid_r, valid_nxt;
  logic               run_ident_r, run_ident_nxt;

  // Read stage of the drain.
  logic               rd_v_r;
  logic               rd_seen_r;
  logic [CNT_W-1:0]   rd_slot_r;
  logic               rd_end_r;
  logic [IDX_W-1:0]   rd_data_r;

  logic [IDX_W-1:0]   inv_mem [MAX_LEN];

  logic [IDX_W-1:0]   idx;
  logic               mem_we;
  logic [MAX_LEN-1:0] need_mask;
  logic [OCC_W-1:0]   occ;
  logic               issue;
  logic               issue_last;

  assign idx       = q_cmd.idx[IDX_W-1:0];
  assign need_mask = ~({MAX_LEN{1'b1}} << count_r);
  assign occ       = OCC_W'(out_cnt) + OCC_W'(rd_v_r) - OCC_W'(out_pop_fire);
  assign issue     = (state_r == pic_pkg::ST_DRAIN) && (occ < OCC_W'(pic_pkg::OUT_DEPTH));
  assign issue_last = (slot_r + 1'b1 == count_r);
  assign q_rd      = (state_r == pic_pkg::ST_LOAD) && !q_empty;
  assign mem_we    = q_rd && !q_cmd.over && !q_cmd.oor && !seen_r[idx];

  always_comb begin
    state_nxt     = state_r;
    seen_nxt      = seen_r;
    count_nxt     = count_r;
    bad_nxt       = bad_r;
    ident_nxt     = ident_r;
    slot_nxt      = slot_r;
    valid_nxt     = valid_r;
    run_ident_nxt = run_ident_r;
    case (state_r)
      pic_pkg::ST_LOAD: begin
        if (q_rd) begin
          if (q_cmd.over) begin
            bad_nxt   = 1'b1;
            ident_nxt = 1'b0;
          end else begin
            if (!q_cmd.ident_ok) begin
              ident_nxt = 1'b0;
            end
            if (q_cmd.oor || seen_r[idx]) begin
              bad_nxt = 1'b1;
            end else begin
              seen_nxt[idx] = 1'b1;
            end
            count_nxt = count_r + 1'b1;
          end
          if (q_cmd.last) begin
            state_nxt = pic_pkg::ST_CHECK;
          end
        end
      end
      pic_pkg::ST_CHECK: begin
        // Valid only if no entry was rejected and every slot below the count is filled.
        valid_nxt     = !bad_r && ((seen_r & need_mask) == need_mask);
        run_ident_nxt = !bad_r && ((seen_r & need_mask) == need_mask) && ident_r;
        slot_nxt      = '0;
        state_nxt     = pic_pkg::ST_DRAIN;
      end
      pic_pkg::ST_DRAIN: begin
        if (issue) begin
          slot_nxt = slot_r + 1'b1;
          if (issue_last) begin
            seen_nxt  = '0;
            count_nxt = '0;
            bad_nxt   = 1'b0;
            ident_nxt = 1'b1;
            state_nxt = pic_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = pic_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pic_pkg::ST_LOAD;
      seen_r      <= '0;
      count_r     <= '0;
      bad_r       <= 1'b0;
      ident_r     <= 1'b1;
      slot_r      <= '0;
      valid_r     <= 1'b0;
      run_ident_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      count_r     <= count_nxt;
      bad_r       <= bad_nxt;
      ident_r     <= ident_nxt;
      slot_r      <= slot_nxt;
      valid_r     <= valid_nxt;
      run_ident_r <= run_ident_nxt;
      rd_v_r      <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_seen_r <= seen_r[slot_r[IDX_W-1:0]];
      rd_slot_r <= slot_r;
      rd_end_r  <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      inv_mem[idx] <= count_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= inv_mem[slot_r[IDX_W-1:0]];
    end
  end

  assign out_wr = rd_v_r;

  always_comb begin
    out_res.inverse_value = rd_seen_r ? pic_pkg::SLOT_W'(rd_data_r) : '0;
    out_res.slot          = pic_pkg::SLOT_W'(rd_slot_r);
    out_res.end_of_run    = rd_end_r;
    out_res.is_valid      = valid_r;
    out_res.is_identity   = run_ident_r;
  end

endmodule

>>> rtl/permutation_inverter_checker_core.sv
// ----------------------------------------------------------------------------
// permutation_inverter_checker_core
// Builds the inverse of a permutation streamed in one entry per item and
// reports whether it was a valid permutation and whether it was the identity.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake        Payload
//   -------  ---------------  ---------------------------------------------
//   input    in_push/in_full  in_entry_value (s32), in_last_entry
//   result   out_pop/out_empty out_inverse_value, out_slot, out_end_of_run,
//                             out_is_valid, out_is_identity
//
// The front accepts one entry per cycle into a two-item queue while it is not
// full; the back takes one entry per cycle from it while loading and updates
// the seen map and inverse table. After the last entry the back runs the
// validity check in a state of its own, then reads the inverse table, which
// has a single read port, one slot per cycle while the result queue has room.
// Reset is synchronous and clears the seen map at once (it is held in
// flip-flops), so there is no clearing pass. Either side may stall freely:
// the entry queue and the two-item result queue decouple them.
// ----------------------------------------------------------------------------
module permutation_inverter_checker_core #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [pic_pkg::ENTRY_W-1:0] in_entry_value,
  input  logic                               in_last_entry,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [pic_pkg::SLOT_W-1:0]         out_inverse_value,
  output logic [pic_pkg::SLOT_W-1:0]         out_slot,
  output logic                               out_end_of_run,
  output logic                               out_is_valid,
  output logic                               out_is_identity
);

  // Entry queue between front and back.
  logic          cmd_wr;
  pic_pkg::cmd_t cmd_in;
  pic_pkg::cmd_t cmd_out;
  logic          cmd_rd;
  logic          cmd_empty;

  // Result queue after the back.
  logic                          res_wr;
  pic_pkg::res_t                 res_in;
  pic_pkg::res_t                 res_out;
  logic                          res_full;
  logic [pic_pkg::OUT_CNT_W-1:0] res_cnt;
  logic                          pop_fire;

  assign pop_fire = out_pop && !out_empty;

  // The front classifies each entry by its position; the seen map and run flags that decide validity live in the back.
  pic_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .q_full         (in_full),
    .in_entry_value (in_entry_value),
    .in_last_entry  (in_last_entry),
    .q_wr           (cmd_wr),
    .q_cmd          (cmd_in)
  );

  pic_fifo #(
    .W     ($bits(pic_pkg::cmd_t)),
    .DEPTH (pic_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (in_full),
    .rd_en   (cmd_rd),
    .rd_data (cmd_out),
    .empty   (cmd_empty),
    .count   ()
  );

  // The back issues a table read only when the result queue is sure to have
  // room for it, counting the read already in flight.
  pic_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (cmd_empty),
    .q_cmd        (cmd_out),
    .q_rd         (cmd_rd),
    .out_cnt      (res_cnt),
    .out_pop_fire (pop_fire),
    .out_wr       (res_wr),
    .out_res      (res_in)
  );

  pic_fifo #(
    .W     ($bits(pic_pkg::res_t)),
    .DEPTH (pic_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_out),
    .empty   (out_empty),
    .count   (res_cnt)
  );

  assign out_inverse_value = res_out.inverse_value;
  assign out_slot          = res_out.slot;
  assign out_end_of_run    = res_out.end_of_run;
  assign out_is_valid      = res_out.is_valid;
  assign out_is_identity   = res_out.is_identity;

  // The read-ahead credit must never let a result arrive at a full queue
  // unless a pop frees a place in the same cycle.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> (!res_full || pop_fire))
    else $error("result written into a full result queue");

  // An identity run is always a valid one.
  a_ident_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_identity) |-> out_is_valid)
    else $error("identity flagged on an invalid permutation");

  // The inverse of the identity maps every slot to itself.
  a_ident_value: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_identity) |-> (out_inverse_value == out_slot))
    else $error("identity run with an inverse entry different from its slot");

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the permutation inverter and checker. Entries
// are streamed in through the push/full side and the inverse read back
// through the pop/empty side. A model of the block in this file predicts
// every result, which is then compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Largest permutation length of the block under test.
  localparam int MAX_LEN = 64;

  // The run is abandoned after this many clock cycles.
  localparam int CYCLE_LIMIT = 200000;

  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;

  // Quiet cycles after the last result, to catch stray results.
  localparam int TAIL_CYCLES = 40;

  // One permutation entry as the sender offers it.
  typedef struct packed {
    logic signed [pic_pkg::ENTRY_W-1:0] value;
    logic                               last;
  } entry_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_push;
  logic                               in_full;
  logic signed [pic_pkg::ENTRY_W-1:0] in_entry_value;
  logic                               in_last_entry;
  logic                               out_empty;
  logic                               out_pop;
  logic [pic_pkg::SLOT_W-1:0]         out_inverse_value;
  logic [pic_pkg::SLOT_W-1:0]         out_slot;
  logic                               out_end_of_run;
  logic                               out_is_valid;
  logic                               out_is_identity;

  permutation_inverter_checker_core #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_entry_value   (in_entry_value),
    .in_last_entry    (in_last_entry),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_inverse_value(out_inverse_value),
    .out_slot         (out_slot),
    .out_end_of_run   (out_end_of_run),
    .out_is_valid     (out_is_valid),
    .out_is_identity  (out_is_identity)
  );

  // --------------------------------------------------------------------------
  // Clock.
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Inverse model. It keeps its own seen map, inverse table and run flags and
  // turns each accepted entry into the results that the block must produce.
  // --------------------------------------------------------------------------
  logic                       seen_slot [MAX_LEN];
  logic [pic_pkg::SLOT_W-1:0] inverse_slot [MAX_LEN];
  int                         run_len;
  logic                       run_broken;
  logic                       run_identity;

  pic_pkg::res_t expected_inverse_q [$];

  // --------------------------------------------------------------------------
  // Cycle limit.
  // --------------------------------------------------------------------------
  int cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_cnt, expected_inverse_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void clear_permutation();
    foreach (seen_slot[i]) seen_slot[i] = 1'b0;
    run_len      = 0;
    run_broken   = 1'b0;
    run_identity = 1'b1;
  endfunction

  function automatic void absorb_entry(logic signed [pic_pkg::ENTRY_W-1:0] value, logic last);
    logic          perm_ok;
    pic_pkg::res_t r;
    if (run_len >= MAX_LEN) begin
      // An entry past the maximum length spoils the run and is dropped.
      run_broken   = 1'b1;
      run_identity = 1'b0;
    end else begin
      if (value < 0 || value != run_len)
        run_identity = 1'b0;
      if (value < 0 || value >= MAX_LEN) begin
        run_broken = 1'b1;
      end else if (seen_slot[value[pic_pkg::SLOT_W-1:0]]) begin
        // A repeated value keeps the first position stored for it.
        run_broken = 1'b1;
      end else begin
        seen_slot[value[pic_pkg::SLOT_W-1:0]]    = 1'b1;
        inverse_slot[value[pic_pkg::SLOT_W-1:0]] = run_len[pic_pkg::SLOT_W-1:0];
      end
      run_len++;
    end
    if (!last)
      return;
    // Valid only if nothing went wrong and every slot below the length is set.
    perm_ok = !run_broken;
    for (int i = 0; i < run_len; i++)
      if (!seen_slot[i])
        perm_ok = 1'b0;
    for (int i = 0; i < run_len; i++) begin
      r.inverse_value = seen_slot[i] ? inverse_slot[i] : '0;
      r.slot          = i[pic_pkg::SLOT_W-1:0];
      r.end_of_run    = (i + 1 == run_len);
      r.is_valid      = perm_ok;
      r.is_identity   = perm_ok && run_identity;
      expected_inverse_q.push_back(r);
    end
    clear_permutation();
  endfunction

  // --------------------------------------------------------------------------
  // Sender. It works in bursts of random length separated by random gaps and
  // holds an item steady while the block reports full.
  // --------------------------------------------------------------------------
  entry_t pending_entry_q [$];
  entry_t next_entry;
  logic   in_taken;
  int     burst_left = 0;
  int     gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (pending_entry_q.size() == 0) begin
        in_push <= 1'b0;
      end else begin
        next_entry     = pending_entry_q.pop_front();
        in_entry_value <= next_entry.value;
        in_last_entry  <= next_entry.last;
        in_push        <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // End of a burst: pick the next burst and, mostly, a gap before it.
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Its stall pattern switches between free running, coin toss and
  // mostly stalled. A request from the stimulus starts one long hold-off,
  // which it counts down on its own.
  // --------------------------------------------------------------------------
  int   hold_request = 0;
  int   hold_served  = 0;
  int   hold_left    = 0;
  int   rx_mode      = 0;
  int   rx_run_left  = 0;
  logic rx_pop;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rx_pop = 1'b0;
    end else if (hold_served != hold_request) begin
      hold_served = hold_request;
      hold_left   = HOLD_CYCLES;
      rx_pop      = 1'b0;
    end else begin
      if (rx_run_left == 0) begin
        rx_mode     = $urandom_range(0, 2);
        rx_run_left = $urandom_range(5, 40);
      end
      rx_run_left--;
      case (rx_mode)
        0:       rx_pop = 1'b1;
        1:       rx_pop = $urandom_range(0, 1);
        default: rx_pop = ($urandom_range(0, 3) == 0);
      endcase
    end
    out_pop <= rst_n && rx_pop;
  end

  // --------------------------------------------------------------------------
  // Monitor. Accepted entries feed the model; accepted results are compared
  // with the oldest expectation.
  // --------------------------------------------------------------------------
  int            err_cnt       = 0;
  int            results_seen  = 0;
  int            runs_seen     = 0;
  int            runs_valid    = 0;
  int            runs_identity = 0;
  int            full_stalls   = 0;
  pic_pkg::res_t want;

  always @(posedge clk) begin
    in_taken = rst_n && in_push && !in_full;
    if (rst_n && in_push && in_full)
      full_stalls++;
    if (in_taken)
      absorb_entry(in_entry_value, in_last_entry);
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (expected_inverse_q.size() == 0) begin
        $error("unexpected result: slot %0d inverse_value %0d", out_slot, out_inverse_value);
        err_cnt++;
      end else begin
        want = expected_inverse_q.pop_front();
        if (out_inverse_value !== want.inverse_value) begin
          $error("inverse_value: expected %0d, got %0d", want.inverse_value, out_inverse_value);
          err_cnt++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          err_cnt++;
        end
        if (out_end_of_run !== want.end_of_run) begin
          $error("end_of_run: expected %0b, got %0b", want.end_of_run, out_end_of_run);
          err_cnt++;
        end
        if (out_is_valid !== want.is_valid) begin
          $error("is_valid: expected %0b, got %0b", want.is_valid, out_is_valid);
          err_cnt++;
        end
        if (out_is_identity !== want.is_identity) begin
          $error("is_identity: expected %0b, got %0b", want.is_identity, out_is_identity);
          err_cnt++;
        end
        if (want.end_of_run) begin
          runs_seen++;
          if (want.is_valid)
            runs_valid++;
          if (want.is_identity)
            runs_identity++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------

  // Queues one permutation, marking its final entry.
  task automatic queue_permutation(input logic signed [pic_pkg::ENTRY_W-1:0] vals [$]);
    entry_t e;
    foreach (vals[i]) begin
      e.value = vals[i];
      e.last  = (i == vals.size() - 1);
      pending_entry_q.push_back(e);
    end
  endtask

  // Waits until every queued item is accepted and every result has come.
  task automatic wait_drained();
    while (pending_entry_q.size() != 0 || in_push || expected_inverse_q.size() != 0)
      @(posedge clk);
  endtask

  logic signed [pic_pkg::ENTRY_W-1:0] work_q [$];
  logic signed [pic_pkg::ENTRY_W-1:0] swap_tmp;
  int n_entries;
  int base_len;
  int kind;
  int pos;
  int swap_idx;
  int rand_items;
  int perm_idx;

  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_entry_value = '0;
    in_last_entry  = 1'b0;
    out_pop        = 1'b0;
    in_taken       = 1'b0;
    clear_permutation();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Single entry identity, a swap and a longer identity.
    work_q = '{0};          queue_permutation(work_q);
    work_q = '{1, 0};       queue_permutation(work_q);
    work_q = '{0, 1, 2};    queue_permutation(work_q);
    // A repeated value, right after its first use and after another entry.
    work_q = '{0, 0};       queue_permutation(work_q);
    work_q = '{1, 0, 1};    queue_permutation(work_q);
    // The most negative and the most positive entry values.
    work_q = '{32'sh8000_0000}; queue_permutation(work_q);
    work_q = '{32'sh7fff_ffff}; queue_permutation(work_q);
    // A value just past the maximum length.
    work_q = '{0, 64};      queue_permutation(work_q);
    // In-range values not below the count leave slots unfilled; the last is a valid rotation.
    work_q = '{63};         queue_permutation(work_q);
    work_q = '{0, 3};       queue_permutation(work_q);
    work_q = '{2, 0, 1};    queue_permutation(work_q);
    wait_drained();

    // The receiver holds off for a long stretch while two permutations are
    // offered, so the result side backs up and the input reports full.
    hold_request++;
    work_q = '{5, 3, 0, 1, 4, 2};                 queue_permutation(work_q);
    work_q = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9};     queue_permutation(work_q);
    wait_drained();

    // Random part. Mostly well-formed permutations with random order, some
    // identities, some with one bad entry, a little pure noise, plus one
    // permutation of the maximum length and one that runs past it.
    rand_items = 0;
    perm_idx   = 0;
    while (rand_items < 160) begin
      if (perm_idx == 4)
        n_entries = MAX_LEN;
      else if (perm_idx == 11)
        n_entries = MAX_LEN + $urandom_range(1, 4);
      else
        n_entries = $urandom_range(1, 10);
      kind     = $urandom_range(0, 99);
      base_len = (n_entries > MAX_LEN) ? MAX_LEN : n_entries;
      work_q.delete();
      for (int i = 0; i < base_len; i++)
        work_q.push_back(i);
      if (kind >= 20) begin
        for (int i = base_len - 1; i > 0; i--) begin
          swap_idx         = $urandom_range(0, i);
          swap_tmp         = work_q[i];
          work_q[i]        = work_q[swap_idx];
          work_q[swap_idx] = swap_tmp;
        end
      end
      for (int i = base_len; i < n_entries; i++)
        work_q.push_back(($urandom_range(0, 1) == 0) ? $urandom_range(0, MAX_LEN - 1) : $urandom);
      if (kind >= 70 && kind < 95) begin
        pos = $urandom_range(0, n_entries - 1);
        case ($urandom_range(0, 4))
          0: work_q[pos] = $urandom;
          1: work_q[pos] = $urandom | 32'h8000_0000;
          2: work_q[pos] = (n_entries > 1) ? work_q[(pos + 1) % n_entries] : MAX_LEN;
          3: work_q[pos] = (n_entries < MAX_LEN) ? $urandom_range(n_entries, MAX_LEN - 1)
                                                 : MAX_LEN;
          default: work_q[pos] = MAX_LEN + $urandom_range(0, 1000000);
        endcase
      end else if (kind >= 95) begin
        foreach (work_q[i]) work_q[i] = $urandom;
      end
      queue_permutation(work_q);
      rand_items += n_entries;
      perm_idx++;
      // Once in the middle the sender stops until everything has drained.
      if (perm_idx == 8)
        wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d permutations (%0d valid, %0d identity).",
             results_seen, runs_seen, runs_valid, runs_identity);
    $display("Input was held off by a full block on %0d cycles.", full_stalls);
    if (err_cnt == 0 && expected_inverse_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> permutation_inverter_checker_core.f
rtl/pic_pkg.sv
rtl/pic_fifo.sv
rtl/pic_front.sv
rtl/pic_back.sv
rtl/permutation_inverter_checker_core.sv
tb/sv/tb_top.sv
